// ===== design/ffra_pkg.sv =====
// Shared types, codes and defaults for the first-fit region allocator.
package ffra_pkg;

    localparam int DEF_REGION_SLOTS = 32;
    localparam int DEF_FREE_SLOTS   = 32;
    localparam int DEF_PAGE_BYTES   = 256;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_XLATE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_BOUNDS    = 3'd3;
    localparam logic [2:0] ST_LIST_FULL = 3'd4;
    localparam logic [2:0] ST_HEAP_OUT  = 3'd5;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    // Which way the datapath closes a transaction.
    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_NOP,
        FIN_BAD_ID,
        FIN_FREE,
        FIN_XLATE,
        FIN_FIT,
        FIN_BUMP
    } fin_t;

    typedef struct packed {
        logic load;
        logic scan_inc;
        logic div_init;
        logic div_step;
        fin_t fin;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       bad_id;
        logic       scan_end;
        logic       scan_fit;
    } dp_stat_t;

endpackage

// ===== design/ffra_ctrl.sv =====
// Sequencing state machine of the region allocator.
module ffra_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ffra_pkg::dp_stat_t stat,
    output ffra_pkg::ctl_cmd_t ctl,
    output logic               busy
);
    import ffra_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DIV,
        S_BUMP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        ctl.fin      = FIN_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                if (stat.cmd != CMD_ALLOC && stat.cmd != CMD_FREE && stat.cmd != CMD_XLATE)
                    ctl.fin = FIN_NOP;
                else if (stat.bad_id)
                    ctl.fin = FIN_BAD_ID;
                else if (stat.cmd == CMD_FREE)
                    ctl.fin = FIN_FREE;
                else if (stat.cmd == CMD_XLATE)
                    ctl.fin = FIN_XLATE;
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    ctl.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else if (stat.scan_fit)
                begin
                    ctl.fin    = FIN_FIT;
                    state_next = S_IDLE;
                end
                else
                    ctl.scan_inc = 1'b1;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                state_next   = S_BUMP;
            end
            S_BUMP:
            begin
                ctl.fin    = FIN_BUMP;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== design/ffra_dp.sv =====
// Datapath: region table, free list, heap top, page rounding and results.
module ffra_dp #(
    parameter int REGION_SLOTS = ffra_pkg::DEF_REGION_SLOTS,
    parameter int FREE_SLOTS   = ffra_pkg::DEF_FREE_SLOTS,
    parameter int PAGE_BYTES   = ffra_pkg::DEF_PAGE_BYTES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ffra_pkg::ctl_cmd_t ctl,
    output ffra_pkg::dp_stat_t stat,
    input  logic [1:0]         cmd,
    input  logic [7:0]         region_id,
    input  logic [31:0]        size,
    input  logic [31:0]        offset,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic [2:0]         status,
    output logic [31:0]        address,
    output logic               from_free_list
);
    import ffra_pkg::*;

    localparam int RIW  = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam int FIW  = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CNTW = $clog2(FREE_SLOTS + 1);
    // reciprocal of the page size: ceil(2^(32+PL) / PAGE_BYTES), exact for 32-bit sizes
    localparam int          PL     = $clog2(PAGE_BYTES);
    localparam logic [32:0] RECIP  = 33'(((64'd1 << (32 + PL)) + 64'(PAGE_BYTES) - 64'd1)
                                        / 64'(PAGE_BYTES));
    localparam logic [31:0] PAGE_W = 32'(PAGE_BYTES);

    // region table, valid bit per entry stands for the all-zero reset
    logic [31:0]             rs_mem [REGION_SLOTS];
    logic [31:0]             re_mem [REGION_SLOTS];
    logic [REGION_SLOTS-1:0] rvld_reg;

    logic [31:0]     fs_reg [FREE_SLOTS];
    logic [31:0]     fe_reg [FREE_SLOTS];
    logic [CNTW-1:0] fcount_reg;
    logic [CNTW-1:0] scan_reg;

    logic [31:0] heap_top_reg;
    logic [31:0] heap_limit_reg;

    logic [1:0]  cmd_reg;
    logic [7:0]  id_reg;
    logic [31:0] size_reg;
    logic [31:0] off_reg;
    logic [31:0] rd_s_reg;
    logic [31:0] rd_e_reg;

    logic [64:0]   prod_reg;
    logic [31:0]   qd_reg;

    logic          done_reg;
    logic [2:0]    status_reg;
    logic [31:0]   addr_reg;
    logic          ffl_reg;

    logic [RIW-1:0] widx;
    logic [RIW-1:0] ridx;
    logic [FIW-1:0] sidx;
    logic [31:0]    cur_s;
    logic [31:0]    cur_e;
    logic [32:0]    fit_end;
    logic           fit_ok;
    logic           fit_exact;
    logic           rg_empty;
    logic           rg_live;
    logic           list_full;
    logic           xl_bad;
    logic [64:0]    quot;
    logic [33:0]    pad;
    logic [33:0]    new_top;
    logic           heap_out;
    logic           do_push;
    logic           do_clear;
    logic           do_drop;
    logic           do_split;
    logic           do_bump;

    assign widx      = id_reg[RIW-1:0];
    assign ridx      = region_id[RIW-1:0];
    assign sidx      = scan_reg[FIW-1:0];
    assign cur_s     = fs_reg[sidx];
    assign cur_e     = fe_reg[sidx];
    assign fit_end   = {1'b0, cur_s} + {1'b0, size_reg};
    assign fit_ok    = (fit_end <= {1'b0, cur_e});
    assign fit_exact = (fit_end == {1'b0, cur_e});

    assign rg_empty  = (rd_s_reg == '0) && (rd_e_reg == '0);
    assign rg_live   = (rd_s_reg < rd_e_reg);
    assign list_full = (fcount_reg >= CNTW'(FREE_SLOTS));
    assign xl_bad    = (rd_e_reg < rd_s_reg) || (off_reg >= (rd_e_reg - rd_s_reg));

    // size rounded up to a page: quotient by reciprocal, then quotient times page
    assign quot      = prod_reg >> (32 + PL);
    assign pad       = (qd_reg == size_reg) ? 34'd0 : 34'(PAGE_BYTES);
    assign new_top   = {2'b0, heap_top_reg} + {2'b0, qd_reg} + pad;
    assign heap_out  = (new_top > {2'b0, heap_limit_reg});

    assign do_push   = (ctl.fin == FIN_FREE) && !rg_empty && rg_live && !list_full;
    assign do_clear  = (ctl.fin == FIN_FREE) && !rg_empty && !(rg_live && list_full);
    assign do_split  = (ctl.fin == FIN_FIT) && !fit_exact;
    assign do_drop   = (ctl.fin == FIN_FIT) && fit_exact;
    assign do_bump   = (ctl.fin == FIN_BUMP) && !heap_out;

    always_comb
    begin
        stat.cmd      = cmd_reg;
        stat.bad_id   = ({1'b0, id_reg} >= 9'(REGION_SLOTS));
        stat.scan_end = (scan_reg >= fcount_reg);
        stat.scan_fit = fit_ok;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvld_reg       <= '0;
            fcount_reg     <= '0;
            scan_reg       <= '0;
            heap_top_reg   <= '0;
            heap_limit_reg <= '1;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= (ctl.fin != FIN_NONE);
            if (ctl.load)
                scan_reg <= '0;
            else if (ctl.scan_inc)
                scan_reg <= scan_reg + CNTW'(1);
            if (do_push)
                fcount_reg <= fcount_reg + CNTW'(1);
            else if (do_drop)
                fcount_reg <= fcount_reg - CNTW'(1);
            if (do_clear)
                rvld_reg[widx] <= 1'b0;
            else if (ctl.fin == FIN_FIT || do_bump)
                rvld_reg[widx] <= 1'b1;
            if (cfg_we && cfg_index == CFG_HEAP_BASE)
                heap_top_reg <= cfg_data;
            else if (do_bump)
                heap_top_reg <= new_top[31:0];
            if (cfg_we && cfg_index == CFG_HEAP_LIMIT)
                heap_limit_reg <= cfg_data;
        end
    end

    // payload: latched transaction, table, free list, page rounding, results
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            id_reg   <= region_id;
            size_reg <= size;
            off_reg  <= offset;
            rd_s_reg <= rvld_reg[ridx] ? rs_mem[ridx] : '0;
            rd_e_reg <= rvld_reg[ridx] ? re_mem[ridx] : '0;
        end

        if (ctl.fin == FIN_FIT)
        begin
            rs_mem[widx] <= cur_s;
            re_mem[widx] <= fit_end[31:0];
        end
        else if (do_bump)
        begin
            rs_mem[widx] <= heap_top_reg;
            re_mem[widx] <= heap_top_reg + size_reg;
        end

        if (do_push)
        begin
            for (int k = 1; k < FREE_SLOTS; k++)
            begin
                fs_reg[k] <= fs_reg[k-1];
                fe_reg[k] <= fe_reg[k-1];
            end
            fs_reg[0] <= rd_s_reg;
            fe_reg[0] <= rd_e_reg;
        end
        else if (do_split)
            fs_reg[sidx] <= fit_end[31:0];
        else if (do_drop)
        begin
            for (int k = 0; k < FREE_SLOTS - 1; k++)
            begin
                if (CNTW'(k) >= scan_reg && CNTW'(k + 1) < fcount_reg)
                begin
                    fs_reg[k] <= fs_reg[k+1];
                    fe_reg[k] <= fe_reg[k+1];
                end
            end
        end

        if (ctl.div_init)
            prod_reg <= {33'd0, size_reg} * {32'd0, RECIP};
        if (ctl.div_step)
            qd_reg <= quot[31:0] * PAGE_W;

        status_reg <= ST_OK;
        addr_reg   <= '0;
        ffl_reg    <= 1'b0;
        case (ctl.fin)
            FIN_BAD_ID:
                status_reg <= ST_BAD_ID;
            FIN_FREE:
            begin
                if (rg_empty)
                    status_reg <= ST_EMPTY;
                else if (rg_live && list_full)
                    status_reg <= ST_LIST_FULL;
            end
            FIN_XLATE:
            begin
                if (rg_empty)
                    status_reg <= ST_EMPTY;
                else if (xl_bad)
                    status_reg <= ST_BOUNDS;
                else
                    addr_reg <= rd_s_reg + off_reg;
            end
            FIN_FIT:
            begin
                addr_reg <= cur_s;
                ffl_reg  <= 1'b1;
            end
            FIN_BUMP:
            begin
                if (heap_out)
                    status_reg <= ST_HEAP_OUT;
                else
                    addr_reg <= heap_top_reg;
            end
            default:
                status_reg <= ST_OK;
        endcase
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign address        = addr_reg;
    assign from_free_list = ffl_reg;

endmodule

// ===== design/first_fit_region_allocator.sv =====
// Top level of the first-fit region allocator.
// A transaction is taken when start is high while busy is low; its result appears on
// status, address and from_free_list for exactly one cycle with done high, and the
// receiver must take it then. Free, translate, bad ids and unused commands finish in
// the check state. Alloc walks the free list one entry per cycle, newest first, and
// stops at the first entry that fits; a miss walks all listed entries, then rounds
// the size up to a page by reciprocal multiplication before the heap top bump.
// Configuration writes apply at once while idle.
module first_fit_region_allocator #(
    parameter int REGION_SLOTS = ffra_pkg::DEF_REGION_SLOTS,
    parameter int FREE_SLOTS   = ffra_pkg::DEF_FREE_SLOTS,
    parameter int PAGE_BYTES   = ffra_pkg::DEF_PAGE_BYTES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  region_id,
    input  logic [31:0] size,
    input  logic [31:0] offset,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] address,
    output logic        from_free_list
);
    import ffra_pkg::*;

    ctl_cmd_t ctl;
    dp_stat_t stat;

    ffra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    ffra_dp #(
        .REGION_SLOTS (REGION_SLOTS),
        .FREE_SLOTS   (FREE_SLOTS),
        .PAGE_BYTES   (PAGE_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .region_id      (region_id),
        .size           (size),
        .offset         (offset),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .status         (status),
        .address        (address),
        .from_free_list (from_free_list)
    );

endmodule

// ===== sim/first_fit_region_allocator_tb.sv =====
// Testbench for the first-fit region allocator: directed, list-full and randomized checks.
`timescale 1ns / 100ps
module first_fit_region_allocator_tb;
    import ffra_pkg::*;

    localparam int SLOTS      = DEF_REGION_SLOTS;
    localparam int FSLOTS     = DEF_FREE_SLOTS;
    localparam int PAGE       = DEF_PAGE_BYTES;
    localparam int STALL_MAX  = 3000;
    localparam int DRAIN_WAIT = 80;

    typedef struct packed {
        logic [2:0]  st;
        logic [31:0] addr;
        logic        ffl;
    } alloc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = CMD_ALLOC;
    logic [7:0]  region_id = '0;
    logic [31:0] size = '0;
    logic [31:0] offset = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_HEAP_BASE;
    logic [31:0] cfg_data = '0;
    logic        done;
    logic [2:0]  status;
    logic [31:0] address;
    logic        from_free_list;

    // shadow state of the allocator
    logic [31:0] m_rstart [SLOTS];
    logic [31:0] m_rend [SLOTS];
    logic [31:0] m_fstart [FSLOTS];
    logic [31:0] m_fend [FSLOTS];
    int          m_fcount;
    logic [31:0] m_top;
    logic [31:0] m_limit;

    alloc_result_t pending_results[$];
    int errors = 0;
    int stall_cycles = 0;
    int burst_left = 0;

    first_fit_region_allocator u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .region_id(region_id), .size(size), .offset(offset), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
        .address(address), .from_free_list(from_free_list)
    );

    always #1 clk = ~clk;

    function automatic void drop_entry(int pos);
        for (int k = pos; k + 1 < m_fcount; k++)
        begin
            m_fstart[k] = m_fstart[k + 1];
            m_fend[k]   = m_fend[k + 1];
        end
        m_fcount--;
    endfunction

    function automatic alloc_result_t predict_op(logic [1:0] c, logic [7:0] id,
                                                 logic [31:0] sz, logic [31:0] off);
        alloc_result_t r;
        logic [63:0] new_top;
        logic [31:0] s;
        logic [31:0] e;
        r = '0;
        r.st = ST_OK;
        if (c == 2'd3)
            return r;
        if (id >= SLOTS)
        begin
            r.st = ST_BAD_ID;
            return r;
        end
        s = m_rstart[id];
        e = m_rend[id];
        if (c == CMD_ALLOC)
        begin
            for (int i = 0; i < m_fcount; i++)
            begin
                if ({32'd0, m_fstart[i]} + sz <= {32'd0, m_fend[i]})
                begin
                    s = m_fstart[i];
                    m_rstart[id] = s;
                    m_rend[id] = s + sz;
                    if ({32'd0, s} + sz < {32'd0, m_fend[i]})
                        m_fstart[i] = s + sz;
                    else
                        drop_entry(i);
                    r.addr = s;
                    r.ffl = 1'b1;
                    return r;
                end
            end
            new_top = {32'd0, m_top} + (({32'd0, sz} + PAGE - 1) / PAGE) * PAGE;
            if (new_top > {32'd0, m_limit})
            begin
                r.st = ST_HEAP_OUT;
                return r;
            end
            m_rstart[id] = m_top;
            m_rend[id] = m_top + sz;
            r.addr = m_top;
            m_top = new_top[31:0];
        end
        else if (c == CMD_FREE)
        begin
            if (s == 0 && e == 0)
                r.st = ST_EMPTY;
            else if (s < e && m_fcount >= FSLOTS)
                r.st = ST_LIST_FULL;
            else
            begin
                if (s < e)
                begin
                    for (int k = m_fcount; k > 0; k--)
                    begin
                        m_fstart[k] = m_fstart[k - 1];
                        m_fend[k]   = m_fend[k - 1];
                    end
                    m_fstart[0] = s;
                    m_fend[0] = e;
                    m_fcount++;
                end
                m_rstart[id] = '0;
                m_rend[id] = '0;
            end
        end
        else
        begin
            if (s == 0 && e == 0)
                r.st = ST_EMPTY;
            else if (e < s || off >= e - s)
                r.st = ST_BOUNDS;
            else
                r.addr = s + off;
        end
        return r;
    endfunction

    // called at a rising edge; returns at the edge that accepted the transaction
    task automatic send_op(logic [1:0] c, logic [7:0] id, logic [31:0] sz, logic [31:0] off);
        start <= 1'b1;
        cmd <= c;
        region_id <= id;
        size <= sz;
        offset <= off;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_op(c, id, sz, off));
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // bursty sender: random gaps between bursts of back-to-back transactions
    task automatic paced_op(logic [1:0] c, logic [7:0] id, logic [31:0] sz, logic [31:0] off);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 15));
        end
        burst_left--;
        send_op(c, id, sz, off);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_HEAP_BASE)
            m_top = val;
        else
            m_limit = val;
    endtask

    task automatic test_directed();
        send_op(CMD_XLATE, 8'd3, 32'd0, 32'd0);          // translate of empty region
        send_op(CMD_FREE, 8'd3, 32'd0, 32'd0);           // free of empty region
        send_op(CMD_ALLOC, 8'd255, 32'hFFFF_FFFF, 32'd0); // bad id
        send_op(2'd3, 8'd200, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(CMD_ALLOC, 8'd0, 32'd0, 32'd0);          // zero size at heap base 0
        send_op(CMD_XLATE, 8'd0, 32'd0, 32'd0);
        send_op(CMD_ALLOC, 8'd1, 32'd300, 32'd0);
        send_op(CMD_ALLOC, 8'd2, 32'd256, 32'd0);
        send_op(CMD_XLATE, 8'd1, 32'd0, 32'd299);
        send_op(CMD_XLATE, 8'd1, 32'd0, 32'd300);        // out of bounds
        send_op(CMD_XLATE, 8'd1, 32'd0, 32'hFFFF_FFFF);
        send_op(CMD_FREE, 8'd1, 32'd0, 32'd0);
        send_op(CMD_ALLOC, 8'd3, 32'd0, 32'd0);          // zero size from list
        send_op(CMD_ALLOC, 8'd4, 32'd100, 32'd0);        // split
        send_op(CMD_ALLOC, 8'd5, 32'd200, 32'd0);        // exact fit
        send_op(CMD_ALLOC, 8'd4, 32'd10, 32'd0);         // over a live region
        send_op(CMD_FREE, 8'd3, 32'd0, 32'd0);           // zero-length region at address 0, seen as empty
        send_op(CMD_ALLOC, 8'd31, 32'hFFFF_FFFF, 32'd0); // heap exhausted
        send_op(CMD_ALLOC, 8'd32, 32'd1, 32'd0);
        send_op(CMD_FREE, 8'd31, 32'd0, 32'd0);
        drain();
    endtask

    task automatic test_list_full();
        for (int i = 0; i < SLOTS; i++)
            paced_op(CMD_ALLOC, i[7:0], 32'($urandom_range(1, 700)), 32'd0);
        for (int i = 0; i < SLOTS; i++)
            paced_op(CMD_FREE, i[7:0], 32'd0, 32'd0);
        paced_op(CMD_ALLOC, 8'd7, 32'h0010_0000, 32'd0);
        paced_op(CMD_FREE, 8'd7, 32'd0, 32'd0);           // list full
        paced_op(CMD_XLATE, 8'd7, 32'd0, 32'd5);
        drain();
    endtask

    task automatic random_op();
        logic [1:0]  c;
        logic [7:0]  id;
        logic [31:0] sz;
        logic [31:0] off;
        int pick;
        pick = $urandom_range(0, 99);
        c = pick < 40 ? CMD_ALLOC : pick < 70 ? CMD_FREE : pick < 95 ? CMD_XLATE : 2'd3;
        id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, SLOTS - 1));
        case ($urandom_range(0, 5))
            0: sz = $urandom;
            1: sz = 32'($urandom_range(1, 16)) * PAGE;
            2: sz = (m_fcount > 0) ? m_fend[0] - m_fstart[0] : 32'd0;
            default: sz = $urandom_range(0, 900);
        endcase
        off = $urandom;
        if (id < SLOTS && $urandom_range(0, 3) != 0)
            off = (m_rend[id] - m_rstart[id]) - 32'($urandom_range(0, 2))
                  + ($urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(0, 50)) * 32'hFFFF_FFFF);
        paced_op(c, id, sz, off);
    endtask

    task automatic test_random();
        logic [31:0] bases [5]  = '{32'd0, 32'hFFFF_F000, 32'h0000_1000, 32'd0, 32'd0};
        logic [31:0] limits [5] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0004_0000, 32'd0, 32'd0};
        bases[3] = $urandom;
        limits[3] = $urandom;
        for (int p = 0; p < 5; p++)
        begin
            write_cfg(CFG_HEAP_LIMIT, limits[p]);
            write_cfg(CFG_HEAP_BASE, bases[p]);
            repeat (140) random_op();
            drain();
        end
    endtask

    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d address=%h", $time, status, address);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
                    errors++;
                end
                if (address !== exp_r.addr)
                begin
                    $display("%0t: address expected %h actual %h", $time, exp_r.addr, address);
                    errors++;
                end
                if (from_free_list !== exp_r.ffl)
                begin
                    $display("%0t: from_free_list expected %0d actual %0d",
                             $time, exp_r.ffl, from_free_list);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_MAX)
        begin
            $display("first_fit_region_allocator_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            m_rstart[i] = '0;
            m_rend[i] = '0;
        end
        m_fcount = 0;
        m_top = '0;
        m_limit = 32'hFFFF_FFFF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_list_full();
        test_random();
        drain();
        if (errors == 0)
            $display("first_fit_region_allocator_tb OK");
        else
            $display("first_fit_region_allocator_tb NOT OK");
        $finish;
    end

endmodule
